// ===== hw/rtl/pmm_pkg.sv =====
// Shared types and constants for the pedal to MIDI message unit.
`timescale 1ns / 1ps

package pmm_pkg;

   localparam int SAMPLE_BITS    = 10;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int HOLD_BITS      = 16;
   localparam int TIME_BITS      = 32;
   localparam int VALUE_BITS     = 14;
   // |(sample - heel) * 16383| fits in this many bits
   localparam int DIV_BITS       = SAMPLE_BITS + VALUE_BITS;
   localparam int DIV_STEPS      = DIV_BITS;
   localparam int CNT_BITS       = $clog2(DIV_STEPS);
   localparam int PROD_BITS      = SAMPLE_BITS + VALUE_BITS + 2;

   localparam logic [SAMPLE_BITS-1:0] TOE_RESET  = SAMPLE_BITS'(1023);
   localparam logic [SAMPLE_BITS-1:0] DZ_RESET   = SAMPLE_BITS'(2);
   localparam logic [HOLD_BITS-1:0]   HOLD_RESET = HOLD_BITS'(10);

   localparam logic [CSR_INDEX_BITS-1:0] REG_MESSAGE_KIND      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONTROLLER_NUMBER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REVERSE_MODE      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEEL_VALUE        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOE_VALUE         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIDI_CHANNEL      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEAD_ZONE         = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_TIME_MS      = 3'd7;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_CC   = 2'd1;
   localparam logic [1:0] KIND_PB   = 2'd2;

   localparam logic [7:0] STATUS_CC = 8'hB0;
   localparam logic [7:0] STATUS_PB = 8'hE0;

   localparam logic [VALUE_BITS-1:0] TOP_CC = VALUE_BITS'(127);
   localparam logic [VALUE_BITS-1:0] TOP_PB = VALUE_BITS'(16383);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [TIME_BITS-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_first;
      logic [6:0] data_second;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic prime;
      logic commit;
      logic mult;
      logic load_div;
      logic div_step;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic pass;
      logic emit;
      logic span_zero;
      logic div_last;
      logic out_free;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

// ===== hw/rtl/pmm_ctrl.sv =====
// Sequencer for the pedal to MIDI message unit.
`timescale 1ns / 1ps

module pmm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pmm_pkg::sts_type  sts,
   output pmm_pkg::cmd_type  cmd
);
   import pmm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (!sts.primed) begin
               cmd.prime = 1'b1;
               state_in  = ST_IDLE;
            end else if (sts.pass) begin
               cmd.commit = 1'b1;
               state_in   = sts.emit ? ST_MUL : ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            state_in     = sts.span_zero ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/pmm_dp.sv =====
// Datapath: config registers, change filter, span mapping with serial divider, result register.
`timescale 1ns / 1ps

module pmm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pmm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pmm_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  pmm_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pmm_pkg::rsp_type                      rsp_payload,
   input  pmm_pkg::cmd_type                      cmd,
   output pmm_pkg::sts_type                      sts
);
   import pmm_pkg::*;

   // configuration
   logic [1:0]             kind_ff;
   logic [6:0]             ctl_num_ff;
   logic                   rev_ff;
   logic [SAMPLE_BITS-1:0] heel_ff;
   logic [SAMPLE_BITS-1:0] toe_ff;
   logic [3:0]             chan_ff;
   logic [SAMPLE_BITS-1:0] dz_ff;
   logic [HOLD_BITS-1:0]   hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_NONE;
         ctl_num_ff <= '0;
         rev_ff     <= 1'b0;
         heel_ff    <= '0;
         toe_ff     <= TOE_RESET;
         chan_ff    <= '0;
         dz_ff      <= DZ_RESET;
         hold_ff    <= HOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MESSAGE_KIND:      kind_ff    <= csr_wdata[1:0];
            REG_CONTROLLER_NUMBER: ctl_num_ff <= csr_wdata[6:0];
            REG_REVERSE_MODE:      rev_ff     <= csr_wdata[0];
            REG_HEEL_VALUE:        heel_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            REG_TOE_VALUE:         toe_ff     <= csr_wdata[SAMPLE_BITS-1:0];
            REG_MIDI_CHANNEL:      chan_ff    <= csr_wdata[3:0];
            REG_DEAD_ZONE:         dz_ff      <= csr_wdata[SAMPLE_BITS-1:0];
            REG_HOLD_TIME_MS:      hold_ff    <= csr_wdata[HOLD_BITS-1:0];
            default:               kind_ff    <= kind_ff;
         endcase
      end
   end

   // captured request and filter state
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [SAMPLE_BITS-1:0] ref_ff;
   logic [TIME_BITS-1:0]   time_ff;
   logic                   primed_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_payload.sample;
         now_ff    <= req_payload.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         time_ff   <= '0;
         primed_ff <= 1'b0;
      end else if (cmd.prime) begin
         ref_ff    <= sample_ff;
         primed_ff <= 1'b1;
      end else if (cmd.commit) begin
         ref_ff  <= sample_ff;
         time_ff <= now_ff;
      end
   end

   logic [TIME_BITS-1:0]   elapsed;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   is_pb;
   logic [VALUE_BITS-1:0]  top;

   assign elapsed = now_ff - time_ff;
   assign diff    = (sample_ff > ref_ff) ? (sample_ff - ref_ff) : (ref_ff - sample_ff);
   assign is_pb   = (kind_ff == KIND_PB);
   assign top     = is_pb ? TOP_PB : TOP_CC;

   // mapping: multiply offset by output range
   logic signed [SAMPLE_BITS:0] offset;
   logic signed [SAMPLE_BITS:0] span;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;

   assign offset  = $signed({1'b0, sample_ff}) - $signed({1'b0, heel_ff});
   assign span    = $signed({1'b0, toe_ff}) - $signed({1'b0, heel_ff});
   assign prod_in = PROD_BITS'(offset) * PROD_BITS'($signed({1'b0, top}));

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= prod_in;
      end
   end

   // restoring divider on magnitudes, one quotient bit per step
   logic [PROD_BITS-1:0]   prod_mag;
   logic [SAMPLE_BITS:0]   span_mag;
   logic [DIV_BITS-1:0]    quot_ff;
   logic [DIV_BITS-1:0]    quot_in;
   logic [SAMPLE_BITS-1:0] rem_ff;
   logic [SAMPLE_BITS-1:0] rem_in;
   logic [SAMPLE_BITS-1:0] dvs_ff;
   logic                   neg_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [SAMPLE_BITS:0]   rem_sh;
   logic                   ge;

   assign prod_mag = prod_ff[PROD_BITS-1] ? (PROD_BITS'(0) - prod_ff) : prod_ff;
   assign span_mag = span[SAMPLE_BITS] ? ((SAMPLE_BITS+1)'(0) - span) : span;
   assign rem_sh   = {rem_ff, quot_ff[DIV_BITS-1]};
   assign ge       = (rem_sh >= {1'b0, dvs_ff});
   assign rem_in   = ge ? SAMPLE_BITS'(rem_sh - {1'b0, dvs_ff}) : rem_sh[SAMPLE_BITS-1:0];
   assign quot_in  = {quot_ff[DIV_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         quot_ff <= prod_mag[DIV_BITS-1:0];
         rem_ff  <= '0;
         dvs_ff  <= span_mag[SAMPLE_BITS-1:0];
         neg_ff  <= prod_ff[PROD_BITS-1] ^ span[SAMPLE_BITS];
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_div) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   // sign, reverse and clamp
   logic signed [PROD_BITS-1:0] q_signed;
   logic signed [PROD_BITS-1:0] mapped;
   logic [VALUE_BITS-1:0]       val_in;
   logic [VALUE_BITS-1:0]       val_ff;

   assign q_signed = neg_ff ? -$signed(PROD_BITS'(quot_ff)) : $signed(PROD_BITS'(quot_ff));
   assign mapped   = rev_ff ? ($signed(PROD_BITS'(top)) - q_signed) : q_signed;

   always_comb begin
      priority if (toe_ff == heel_ff) begin
         val_in = '0;
      end else if (mapped < 0) begin
         val_in = '0;
      end else if (mapped > $signed(PROD_BITS'(top))) begin
         val_in = top;
      end else begin
         val_in = mapped[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         val_ff <= val_in;
      end
   end

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      if (is_pb) begin
         rsp_in.status_byte = STATUS_PB | {4'b0, chan_ff};
         rsp_in.data_first  = val_ff[6:0];
         rsp_in.data_second = val_ff[13:7];
      end else begin
         rsp_in.status_byte = STATUS_CC | {4'b0, chan_ff};
         rsp_in.data_first  = ctl_num_ff;
         rsp_in.data_second = val_ff[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.primed    = primed_ff;
   assign sts.pass      = (elapsed > TIME_BITS'(hold_ff)) && (diff > dz_ff);
   assign sts.emit      = (kind_ff == KIND_CC) || (kind_ff == KIND_PB);
   assign sts.span_zero = (toe_ff == heel_ff);
   assign sts.div_last  = (cnt_ff == CNT_BITS'(DIV_STEPS - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== hw/rtl/pedal_to_midi_message_unit.sv =====
// A mapped request runs through the check, multiply, divider load, 24-step divide, finish and
// output states (a zero span skips the divide), and output waits while a stalled result is
// untaken; a request that is filtered out or only primes the reference goes back to idle.
// The result register holds a finished message while the next request is taken.
// Reset (synchronous, active high) restores register defaults and unprimes the filter.
`timescale 1ns / 1ps

module pedal_to_midi_message_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pmm_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pmm_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [pmm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pmm_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import pmm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pmm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over an untaken one");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

   a_prime_commit_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.prime, cmd.commit, cmd.take}))
      else $error("conflicting filter state updates");

endmodule
